[hdl/tse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the tab stop expander: character codes,
// configuration register indexes, the reset stop map and stream widths.
// ----------------------------------------------------------------------------
package tse_pkg;

    // character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // column tracking
    localparam int         COLUMN_W   = 10;
    localparam logic [9:0] COLUMN_MIN = 10'd1;
    localparam logic [9:0] COLUMN_MAX = 10'd1023;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int REPEAT_W = 9;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int WORD_BITS  = 64;
    localparam int MAX_COLUMNS = 512;

    // register indexes of the stop map words
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAB_STOPS_WORD0 = 4'd0,
        REG_TAB_STOPS_WORD1 = 4'd1,
        REG_TAB_STOPS_WORD2 = 4'd2,
        REG_TAB_STOPS_WORD3 = 4'd3,
        REG_TAB_STOPS_WORD4 = 4'd4,
        REG_TAB_STOPS_WORD5 = 4'd5,
        REG_TAB_STOPS_WORD6 = 4'd6,
        REG_TAB_STOPS_WORD7 = 4'd7
    } cfg_reg_t;

    // reset stops at columns 1, 9, 17, ... 73 (bit i is column i+1)
    localparam logic [MAX_COLUMNS-1:0] RESET_STOPS = {
        {(MAX_COLUMNS - 2 * WORD_BITS){1'b0}},
        64'h0000_0000_0000_0101,
        64'h0101_0101_0101_0101
    };

    // one-hot to binary masks within a 64-bit segment
    localparam logic [WORD_BITS-1:0] OFF_MASK [6] = '{
        64'hAAAA_AAAA_AAAA_AAAA,
        64'hCCCC_CCCC_CCCC_CCCC,
        64'hF0F0_F0F0_F0F0_F0F0,
        64'hFF00_FF00_FF00_FF00,
        64'hFFFF_0000_FFFF_0000,
        64'hFFFF_FFFF_0000_0000
    };

endpackage

[hdl/tab_stop_expander_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_stop_expander_core
// Expands tabs in a byte stream against a programmable stop map, tracking
// the output column. Each result is a character with a repeat count.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata fields (low bit up)            | tuser/tlast
//  --------+-----------+--------------------------------------+------------
//  s_      | in        | char_in[7:0]                         | none
//  m_      | out       | out_char[7:0], repeat_count[16:8]    | none
//  cfg_wr  | in        | index selects stop map word 0..7     | none
//
//  One transaction per cycle sustained while m_tready is high; each result
//  is registered from the input register. The per-item rate is set by the
//  column update loop: the next-stop search (segmented priority encoder) and
//  the column update complete in the single stage between input and result
//  registers. A tab with no stop beyond yields no result. Reset restores
//  column 1 and the default stops; m_tready low holds the result while one
//  more input transaction is still taken into the input register.
// ----------------------------------------------------------------------------
module tab_stop_expander_core #(
    parameter int TAB_COLUMNS = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream: char_in[7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tse_pkg::S_TDATA_W-1:0]     s_tdata,
    // result stream: out_char[7:0], repeat_count[16:8], zero pad[23:17]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tse_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tse_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import tse_pkg::*;

    localparam int SEGS  = (TAB_COLUMNS + WORD_BITS - 1) / WORD_BITS;
    localparam int PAD_W = SEGS * WORD_BITS;

    // registers
    logic [TAB_COLUMNS-1:0] stops_reg;
    logic [COLUMN_W-1:0]    column_reg, column_next;
    logic                   in_valid_reg;
    logic [CHAR_W-1:0]      in_char_reg;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic [REPEAT_W-1:0]    repeat_reg, repeat_next;

    // handshake
    logic out_free;
    logic advance;
    logic has_result;

    // stop search
    logic [PAD_W-1:0]     stops_pad;
    logic [PAD_W-1:0]     masked_all;
    logic [WORD_BITS-1:0] seg_bits   [SEGS];
    logic [WORD_BITS-1:0] seg_lowest [SEGS];
    logic [5:0]           seg_off    [SEGS];
    logic [SEGS-1:0]      seg_any;
    logic                 stop_found;
    logic [COLUMN_W-1:0]  stop_pos;
    logic [COLUMN_W-1:0]  stop_col;
    logic [COLUMN_W-1:0]  run_len;

    // flow control: the input register drains whenever the result slot frees
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // configuration words and reset stops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stops_reg <= RESET_STOPS[TAB_COLUMNS-1:0];
        end else if (cfg_wr_en) begin
            for (int j = 0; j < TAB_COLUMNS; j++) begin
                if (cfg_wr_index == CFG_IDX_W'(j >> 6)) begin
                    stops_reg[j] <= cfg_wr_data[j & (WORD_BITS - 1)];
                end
            end
        end
    end

    // keep only stops strictly above the current column
    assign stops_pad = PAD_W'(stops_reg);

    always_comb begin
        for (int j = 0; j < PAD_W; j++) begin
            masked_all[j] = stops_pad[j] && (COLUMN_W'(j) >= column_reg);
        end
    end

    // lowest set bit in each 64-bit segment
    always_comb begin
        for (int k = 0; k < SEGS; k++) begin
            seg_bits[k]   = masked_all[k*WORD_BITS +: WORD_BITS];
            seg_lowest[k] = seg_bits[k] & (~seg_bits[k] + 64'd1);
            seg_any[k]    = |seg_bits[k];
            for (int b = 0; b < 6; b++) begin
                seg_off[k][b] = |(seg_lowest[k] & OFF_MASK[b]);
            end
        end
    end

    // first segment holding a stop
    always_comb begin
        stop_found = 1'b0;
        stop_pos   = '0;
        for (int k = SEGS - 1; k >= 0; k--) begin
            if (seg_any[k]) begin
                stop_found = 1'b1;
                stop_pos   = COLUMN_W'(k * WORD_BITS) | COLUMN_W'(seg_off[k]);
            end
        end
    end

    assign stop_col = stop_pos + COLUMN_W'(1);
    assign run_len  = stop_col - column_reg;

    // result and next column for the item in the input register
    always_comb begin
        has_result    = 1'b1;
        out_char_next = in_char_reg;
        repeat_next   = REPEAT_W'(1);
        column_next   = column_reg;
        case (in_char_reg)
            CH_TAB: begin
                has_result    = stop_found;
                out_char_next = CH_SPACE;
                repeat_next   = run_len[REPEAT_W-1:0];
                if (stop_found) begin
                    column_next = stop_col;
                end
            end
            CH_BS: begin
                if (column_reg > COLUMN_MIN) begin
                    column_next = column_reg - COLUMN_W'(1);
                end
            end
            CH_NL: begin
                column_next = COLUMN_MIN;
            end
            default: begin
                if (column_reg < COLUMN_MAX) begin
                    column_next = column_reg + COLUMN_W'(1);
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
        end
    end

    // column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= COLUMN_MIN;
        end else if (advance) begin
            column_reg <= column_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_char_reg <= out_char_next;
            repeat_reg   <= repeat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({repeat_reg, out_char_reg});

endmodule
